>>> rtl/lhas_pkg.sv
// Shared constants, operation codes and control types for the set probe block.
package lhas_pkg;

	localparam int SET_DEPTH = 64;
	localparam int KEY_WIDTH = 64;
	localparam int IDX_W     = $clog2(SET_DEPTH);
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_BUILD  = 2'd1;
	localparam logic [1:0] OP_PROBE  = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic apply_build;
		logic apply_probe;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

endpackage

>>> rtl/lhas_ctrl.sv
// Controller state machine: sequences start, lookup, insert and result beats.
module lhas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic              element_valid,
	output logic              out_valid,
	input  logic              out_ready,
	output lhas_pkg::dp_cmd_t cmd,
	input  lhas_pkg::dp_sts_t sts
);
	import lhas_pkg::*;

	state_t state_q, state_nxt;
	logic   build_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_START: cmd.clear = 1'b1;
						OP_BUILD, OP_PROBE: begin
							if (element_valid) begin
								cmd.load  = 1'b1;
								state_nxt = S_SCAN;
							end
						end
						OP_FINISH: begin
							if (out_free) begin
								cmd.out_load = 1'b1;
							end else begin
								state_nxt = S_HOLD;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					cmd.apply_build = build_q;
					cmd.apply_probe = !build_q;
					state_nxt       = S_IDLE;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			build_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				build_q <= (operation == OP_BUILD);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/lhas_dpath.sv
// Datapath: key memory, fill count, scan pipeline, row flags and result register.
module lhas_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [63:0]                     element_key,
	input  logic                            cfg_valid,
	input  logic                            match_mode,
	output logic                            answer,
	output logic                            set_overflow,
	input  lhas_pkg::dp_cmd_t               cmd,
	output lhas_pkg::dp_sts_t               sts
);
	import lhas_pkg::*;

	logic [KEY_WIDTH-1:0] key_mem [SET_DEPTH];
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] rd_key_s1;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     issue_idx_q;
	logic                 cmp_vld_s1;
	logic                 hit_q;
	logic                 some_hit_q;
	logic                 some_miss_q;
	logic                 dropped_q;
	logic                 mode_q;
	logic                 answer_q;
	logic                 overflow_q;
	logic                 issue;
	logic                 insert;

	// Slots fill in order, so the fill count alone marks which entries are live.
	assign issue  = cmd.scan && (issue_idx_q != fill_q) && !hit_q;
	assign insert = cmd.apply_build && !hit_q && (fill_q != CNT_W'(SET_DEPTH));

	assign sts.scan_done = hit_q || ((issue_idx_q == fill_q) && !cmp_vld_s1);

	assign answer       = answer_q;
	assign set_overflow = overflow_q;

	always_ff @(posedge clk) begin
		if (insert) begin
			key_mem[fill_q[IDX_W-1:0]] <= key_q;
		end
		rd_key_s1 <= key_mem[issue_idx_q[IDX_W-1:0]];
		if (cmd.load) begin
			key_q <= element_key[KEY_WIDTH-1:0];
		end
		if (cmd.out_load) begin
			answer_q   <= mode_q ? !some_miss_q : some_hit_q;
			overflow_q <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			issue_idx_q <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			some_hit_q  <= 1'b0;
			some_miss_q <= 1'b0;
			dropped_q   <= 1'b0;
			mode_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= match_mode;
			end
			if (cmd.load) begin
				issue_idx_q <= '0;
				cmp_vld_s1  <= 1'b0;
				hit_q       <= 1'b0;
			end else begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					issue_idx_q <= issue_idx_q + CNT_W'(1);
				end
				if (cmp_vld_s1 && (rd_key_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				fill_q      <= '0;
				some_hit_q  <= 1'b0;
				some_miss_q <= 1'b0;
				dropped_q   <= 1'b0;
			end else begin
				if (insert) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				if (cmd.apply_build && !hit_q && (fill_q == CNT_W'(SET_DEPTH))) begin
					dropped_q <= 1'b1;
				end
				if (cmd.apply_probe) begin
					if (hit_q) begin
						some_hit_q <= 1'b1;
					end else begin
						some_miss_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

>>> rtl/list_has_any_or_all_set_probe_top.sv
// Top level of the set intersection membership test block.
//
// Usage: a row is sent as a stream of beats on the input channel. A start beat
// clears the set, build beats insert their keys, probe beats look their keys
// up, and a finish beat produces one beat on the output channel carrying the
// row answer and the overflow flag. Null elements are accepted and ignored.
// The match mode register is written through the configuration channel, which
// is always ready; it selects the any test (0) or the all test (1).
// Start and null beats leave the input ready. A finish beat holds the input
// until the output register is free. A build or probe beat with a present key
// walks the stored keys one memory read per cycle and stops early on a hit;
// the key memory has a single read port.
// A finish result is loaded into the output register once that register is free.
// Reset empties the set, clears all row flags and the mode, and drops any
// pending result. When the receiver stalls, the result waits in the output
// register; further non-finish beats are still taken, and a second finish
// waits until the held result has been taken.
module list_has_any_or_all_set_probe_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] element_key,
	input  logic        element_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        answer,
	output logic        set_overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        match_mode
);
	import lhas_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Configuration writes must be made only while the block is idle; the block
	// does not enforce this itself. They are always taken.
	assign cfg_ready = 1'b1;

	// The controller decides what each beat does; the datapath holds the set.
	lhas_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.element_valid (element_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	lhas_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.element_key  (element_key),
		.cfg_valid    (cfg_valid),
		.match_mode   (match_mode),
		.answer       (answer),
		.set_overflow (set_overflow),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

>>> rtl/lhas_chk.sv
// Port level checker for the set probe block, bound to the top level.
module lhas_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic        answer,
	input logic        set_overflow,
	input logic        cfg_ready
);
	import lhas_pkg::*;

	// A held result beat keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(set_overflow))
		else $error("result beat changed while stalled");

	// Only a finish beat creates a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation != OP_FINISH) && !out_valid |=> !out_valid)
		else $error("result beat without a finish");

	// A finish taken with the output empty shows its result on the next cycle.
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_FINISH) && !out_valid |=> out_valid)
		else $error("finish produced no result");

	// A start beat leaves the input ready on the next cycle.
	a_start_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_START) |=> in_ready)
		else $error("start beat stalled the input");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind list_has_any_or_all_set_probe_top lhas_chk u_lhas_chk (.*);

>>> tb/sv/membership_checker.sv
// Checker for the set probe block: tracks the set and row flags and compares row answers.
module membership_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] element_key,
	input  logic        element_valid,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        answer,
	input  logic        set_overflow,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        match_mode,
	output int          results_owed,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import lhas_pkg::*;

	typedef struct packed {
		logic answer;
		logic overflow;
	} row_result_t;

	logic [KEY_WIDTH-1:0] set_keys [SET_DEPTH];
	int                   set_fill;
	logic                 probe_hit;
	logic                 probe_miss;
	logic                 overflowed;
	logic                 mode_all;
	row_result_t          answers_due [$];
	int                   fails = 0;

	assign fail_count = fails;

	// Slots fill in order, so only the first set_fill entries are ever looked at.
	function automatic logic set_holds(input logic [KEY_WIDTH-1:0] k);
		for (int i = 0; i < set_fill; i++) begin
			if (set_keys[i] == k)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void log_fail(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t ns: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_result_t          want;
		logic [KEY_WIDTH-1:0] k;
		if (!arst_n) begin
			set_fill   = 0;
			probe_hit  = 1'b0;
			probe_miss = 1'b0;
			overflowed = 1'b0;
			mode_all   = 1'b0;
			answers_due.delete();
			results_owed <= 0;
		end else begin
			// The result beat is compared first: a row answer never leaves in the
			// same cycle as the finish beat that asks for it.
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					log_fail($sformatf("result beat with no row finished: answer %0b overflow %0b",
						answer, set_overflow));
				end else begin
					want = answers_due.pop_front();
					if (want.answer !== answer)
						log_fail($sformatf("answer expected %0b, got %0b",
							want.answer, answer));
					if (want.overflow !== set_overflow)
						log_fail($sformatf("set_overflow expected %0b, got %0b",
							want.overflow, set_overflow));
				end
			end
			if (cfg_valid && cfg_ready)
				mode_all = match_mode;
			if (in_valid && in_ready) begin
				k = element_key[KEY_WIDTH-1:0];
				case (operation)
					OP_START: begin
						set_fill   = 0;
						probe_hit  = 1'b0;
						probe_miss = 1'b0;
						overflowed = 1'b0;
					end
					OP_BUILD: begin
						if (element_valid && !set_holds(k)) begin
							if (set_fill < SET_DEPTH) begin
								set_keys[set_fill] = k;
								set_fill++;
							end else begin
								overflowed = 1'b1;
							end
						end
					end
					OP_PROBE: begin
						if (element_valid) begin
							if (set_holds(k))
								probe_hit = 1'b1;
							else
								probe_miss = 1'b1;
						end
					end
					default: begin
						want.answer   = mode_all ? !probe_miss : probe_hit;
						want.overflow = overflowed;
						answers_due.push_back(want);
					end
				endcase
			end
			results_owed <= answers_due.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Top of the set probe testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lhas_pkg::*;

	// Roughly how many input beats the random part sends, and how many of the
	// last ones go out with no idling on either side.
	localparam int ITEM_TARGET    = 550;
	localparam int CALM_TAIL      = 60;
	// A present key keeps the lookup busy while it walks the stored keys, so
	// this many quiet cycles after the last result means the block is idle.
	localparam int SETTLE_CYCLES  = SET_DEPTH + 8;
	// Length of the one long receiver hold-off.
	localparam int HOLD_CYCLES    = 300;
	// Cycles with no beat on any channel before the run is declared hung.
	// The worst honest gap is the long hold-off plus a settle pause.
	localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + SETTLE_CYCLES);

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [1:0]  operation     = OP_START;
	logic [63:0] element_key   = '0;
	logic        element_valid = 1'b0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        answer;
	logic        set_overflow;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        match_mode    = 1'b0;

	int results_owed;
	int fail_count;

	// State of the stimulus, receiver and watchdog; calm and long_hold_req are shared.
	bit calm          = 1'b0;
	bit long_hold_req = 1'b0;
	bit hold_asked    = 1'b0;
	int items_sent    = 0;
	int quiet_cycles  = 0;

	// Keys of the current row; build and probe beats draw from it so that
	// probes hit often and duplicates show up in the build list.
	logic [63:0] key_pool [8];
	int          pool_size;

	list_has_any_or_all_set_probe_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.element_key   (element_key),
		.element_valid (element_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.answer        (answer),
		.set_overflow  (set_overflow),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.match_mode    (match_mode)
	);

	membership_checker membership_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.element_key   (element_key),
		.element_valid (element_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.answer        (answer),
		.set_overflow  (set_overflow),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.match_mode    (match_mode),
		.results_owed  (results_owed),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A key that is mostly fully random, with the all-zero and all-one
	// patterns and single set bits mixed in.
	function automatic logic [63:0] rand_key();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offers one beat and returns at the edge where it is taken. Valid is
	// lowered only for an idle burst, never in the step where it is raised.
	task automatic send_item(input logic [1:0] op, input logic [63:0] key, input logic present);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		element_key   <= key;
		element_valid <= present;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Waits until every row answer has come back, then gives any lookup still
	// walking the set time to finish, so the block is idle afterwards.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_valid  <= 1'b1;
		match_mode <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pool keys are sometimes one bit away from the previous one, so near
	// misses get probed as well as exact matches.
	task automatic fill_pool();
		pool_size = $urandom_range(2, 8);
		for (int i = 0; i < pool_size; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
			else
				key_pool[i] = rand_key();
		end
	endtask

	// A well-formed row: start, a short build list, a short probe list, finish.
	// Now and then the start is left out so the row builds on the old set,
	// and now and then the finish is repeated.
	task automatic run_row();
		int n_build;
		int n_probe;
		if ($urandom_range(0, 9) != 0)
			send_item(OP_START, rand_key(), 1'($urandom_range(0, 1)));
		fill_pool();
		n_build = $urandom_range(0, 6);
		for (int i = 0; i < n_build; i++)
			send_item(OP_BUILD, key_pool[$urandom_range(0, pool_size - 1)],
				$urandom_range(0, 7) != 0);
		n_probe = $urandom_range(0, 6);
		for (int i = 0; i < n_probe; i++)
			send_item(OP_PROBE,
				($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, pool_size - 1)]
				                            : rand_key(),
				$urandom_range(0, 7) != 0);
		send_item(OP_FINISH, rand_key(), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 7) == 0)
			send_item(OP_FINISH, rand_key(), 1'($urandom_range(0, 1)));
	endtask

	// Broken sequences: beats of any kind in any order.
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_item(2'($urandom_range(0, 3)),
				($urandom_range(0, 1) != 0) ? key_pool[$urandom_range(0, pool_size - 1)]
				                            : rand_key(),
				1'($urandom_range(0, 1)));
	endtask

	// Fills the set past its capacity. Each key carries its index in the low
	// half, so all of them are distinct. A repeat of a stored key once the set
	// is full must not count as dropped; the dropped keys must probe as misses.
	task automatic run_full_row();
		logic [63:0] built [SET_DEPTH + 4];
		send_item(OP_START, rand_key(), 1'b1);
		for (int i = 0; i < SET_DEPTH + 4; i++) begin
			built[i] = {$urandom, 32'(i)};
			send_item(OP_BUILD, built[i], 1'b1);
		end
		send_item(OP_BUILD, built[5], 1'b1);
		send_item(OP_PROBE, built[0], 1'b1);
		send_item(OP_PROBE, built[SET_DEPTH - 1], 1'b1);
		send_item(OP_PROBE, built[SET_DEPTH], 1'b1);
		send_item(OP_FINISH, '0, 1'b0);
	endtask

	// Receiver: runs of ready, short stalls, and once a long hold-off so the
	// held result blocks the next finish and the input channel backs up.
	initial begin
		wait (arst_n);
		forever begin
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int rows;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// Directed part, any mode. A finish straight after reset sees an empty
		// row and must answer false.
		send_item(OP_FINISH, '0, 1'b0);
		send_item(OP_START, '1, 1'b1);
		send_item(OP_BUILD, '0, 1'b1);
		send_item(OP_BUILD, '1, 1'b1);
		// A duplicate takes no new slot, and null elements are skipped.
		send_item(OP_BUILD, '1, 1'b1);
		send_item(OP_BUILD, 64'h0000_0000_0000_1234, 1'b0);
		send_item(OP_PROBE, 64'h0000_0000_0000_1234, 1'b0);
		// No present probe yet, so the answer is false.
		send_item(OP_FINISH, '1, 1'b1);
		send_item(OP_PROBE, '1, 1'b1);
		send_item(OP_PROBE, 64'd5, 1'b1);
		// One hit is enough; a repeated finish gives the same answer again.
		send_item(OP_FINISH, '0, 1'b1);
		send_item(OP_FINISH, '0, 1'b0);

		// All mode. The mode is read at finish, so the flags of the row above
		// now give false because of its miss.
		settle();
		write_mode(1'b1);
		send_item(OP_FINISH, '0, 1'b0);
		// An empty probe list is true in all mode.
		send_item(OP_START, '0, 1'b0);
		send_item(OP_FINISH, '0, 1'b0);
		send_item(OP_BUILD, 64'h8000_0000_0000_0001, 1'b1);
		send_item(OP_PROBE, 64'h8000_0000_0000_0001, 1'b1);
		send_item(OP_FINISH, '0, 1'b0);
		send_item(OP_PROBE, '0, 1'b1);
		send_item(OP_FINISH, '0, 1'b0);
		settle();
		items_sent = 0;

		// Random part. The mode changes every few rows while the block is idle,
		// two rows overflow the set, and the long hold-off is asked for once.
		fill_pool();
		rows = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= ITEM_TARGET - CALM_TAIL)
				calm = 1'b1;
			if (!hold_asked && items_sent >= 200) begin
				hold_asked    = 1'b1;
				long_hold_req = 1'b1;
			end
			if (rows == 3 || rows == 20)
				run_full_row();
			else if ($urandom_range(0, 9) == 0)
				noise_burst();
			else
				run_row();
			rows++;
			if (rows % 6 == 0 && !calm) begin
				settle();
				write_mode(1'($urandom_range(0, 1)));
			end
		end

		settle();
		if (fail_count == 0 && results_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lhas_pkg.sv
rtl/lhas_ctrl.sv
rtl/lhas_dpath.sv
rtl/list_has_any_or_all_set_probe_top.sv
rtl/lhas_chk.sv
tb/sv/membership_checker.sv
tb/sv/tb.sv
